>>> rtl/core/si_pkg.sv
package si_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int DET_W       = PROD_W + 1;
    localparam int QUO_W       = DIFF_W;
    localparam int NUM_W       = DET_W + QUO_W;

    typedef logic [1:0] sgn_t;

    typedef struct packed {
        logic                          hit;
        logic                          neg_x;
        logic                          neg_y;
        logic signed [COORD_WIDTH-1:0] start_x;
        logic signed [COORD_WIDTH-1:0] start_y;
        logic [DET_W-1:0]              den;
        logic [DET_W-1:0]              rem_x;
        logic [DET_W-1:0]              rem_y;
        logic [QUO_W-1:0]              low_x;
        logic [QUO_W-1:0]              low_y;
        logic [QUO_W-1:0]              quo_x;
        logic [QUO_W-1:0]              quo_y;
    } si_div_t;

    function automatic sgn_t sgn_of(input logic signed [DET_W-1:0] v);
        sgn_of = {v[DET_W-1], (v != '0)};
    endfunction

endpackage

>>> rtl/core/si_cell.sv
module si_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  si_pkg::si_div_t in_data,
    output logic            out_valid,
    output si_pkg::si_div_t out_data
);
    import si_pkg::*;

    logic    valid_reg;
    si_div_t data_reg;
    si_div_t data_next;
    logic [DET_W:0] tx;
    logic [DET_W:0] ty;
    logic [DET_W:0] dw;

    always_comb
    begin
        data_next = in_data;
        dw = {1'b0, in_data.den};
        tx = {in_data.rem_x, in_data.low_x[QUO_W-1]};
        ty = {in_data.rem_y, in_data.low_y[QUO_W-1]};
        data_next.low_x = {in_data.low_x[QUO_W-2:0], 1'b0};
        data_next.low_y = {in_data.low_y[QUO_W-2:0], 1'b0};
        if (tx >= dw)
        begin
            data_next.rem_x = DET_W'(tx - dw);
            data_next.quo_x = {in_data.quo_x[QUO_W-2:0], 1'b1};
        end
        else
        begin
            data_next.rem_x = tx[DET_W-1:0];
            data_next.quo_x = {in_data.quo_x[QUO_W-2:0], 1'b0};
        end
        if (ty >= dw)
        begin
            data_next.rem_y = DET_W'(ty - dw);
            data_next.quo_y = {in_data.quo_y[QUO_W-2:0], 1'b1};
        end
        else
        begin
            data_next.rem_y = ty[DET_W-1:0];
            data_next.quo_y = {in_data.quo_y[QUO_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/core/segment_intersection.sv
// Segment pair intersection pipeline.
// The input channel (in_valid, in_ready) takes one request per cycle while
// in_ready is high: two segments A and B as signed coordinates with four
// fraction bits, and the check_both flag that also tests A's endpoints
// against B's line. The output channel (out_valid, out_ready) returns one
// result per request, in order: hit, and the intersection point, which is
// zero without a hit. From acceptance to out_valid a request passes five
// arithmetic stages (differences, products, determinants, side and range
// decision, numerator products), one divider cell per quotient bit (17
// cells, both axes in each cell), and the output register. Throughput is one
// request per cycle without stalls, set by the pipelined divider chain.
// Reset clears every valid bit, so the block comes up empty and ready.
// When the receiver stalls, the whole pipeline holds, in_ready drops, and
// the waiting result stays unchanged on the output ports.
module segment_intersection (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [si_pkg::COORD_WIDTH-1:0] seg_a_start_x,
    input  logic signed [si_pkg::COORD_WIDTH-1:0] seg_a_start_y,
    input  logic signed [si_pkg::COORD_WIDTH-1:0] seg_a_end_x,
    input  logic signed [si_pkg::COORD_WIDTH-1:0] seg_a_end_y,
    input  logic signed [si_pkg::COORD_WIDTH-1:0] seg_b_start_x,
    input  logic signed [si_pkg::COORD_WIDTH-1:0] seg_b_start_y,
    input  logic signed [si_pkg::COORD_WIDTH-1:0] seg_b_end_x,
    input  logic signed [si_pkg::COORD_WIDTH-1:0] seg_b_end_y,
    input  logic                                  check_both,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  hit,
    output logic signed [si_pkg::COORD_WIDTH-1:0] cross_x,
    output logic signed [si_pkg::COORD_WIDTH-1:0] cross_y
);
    import si_pkg::*;

    localparam int W = COORD_WIDTH;

    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, vo_reg;

    // Stage 1: coordinate differences.
    logic signed [DIFF_W-1:0] dax_reg, day_reg, dbx_reg, dby_reg, ox_reg, oy_reg;
    logic signed [DIFF_W-1:0] e1x_reg, e1y_reg, f1x_reg, f1y_reg;
    logic signed [W-1:0]      bx1_reg, by1_reg;
    logic                     both1_reg;

    // Stage 2: products.
    logic signed [PROD_W-1:0] pd0_reg, pd1_reg, pr0_reg, pr1_reg, ps0_reg, ps1_reg;
    logic signed [PROD_W-1:0] pa0_reg, pa1_reg, pb0_reg, pb1_reg;
    logic signed [DIFF_W-1:0] dbx2_reg, dby2_reg;
    logic signed [W-1:0]      bx2_reg, by2_reg;
    logic                     both2_reg;

    // Stage 3: determinants.
    logic signed [DET_W-1:0]  d_reg, rn_reg, sn_reg, oa_reg, ob_reg;
    logic signed [DIFF_W-1:0] dbx3_reg, dby3_reg;
    logic signed [W-1:0]      bx3_reg, by3_reg;
    logic                     both3_reg;

    // Stage 4: decision.
    logic                     hit4_reg;
    logic [DET_W-1:0]         den4_reg, rn4_reg;
    logic [DIFF_W-1:0]        mx4_reg, my4_reg;
    logic                     nx4_reg, ny4_reg;
    logic signed [W-1:0]      bx4_reg, by4_reg;

    // Stage 5: numerators.
    logic [NUM_W-1:0]         nx5_reg, ny5_reg;
    logic [DET_W-1:0]         den5_reg;
    logic                     hit5_reg, negx5_reg, negy5_reg;
    logic signed [W-1:0]      bx5_reg, by5_reg;

    logic                     hit_reg;
    logic signed [W-1:0]      cx_reg, cy_reg;

    function automatic logic signed [DIFF_W-1:0] dif(input logic signed [W-1:0] a,
                                                     input logic signed [W-1:0] b);
        dif = DIFF_W'($signed({a[W-1], a}) - $signed({b[W-1], b}));
    endfunction

    assign adv      = !vo_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dax_reg   <= dif(seg_a_end_x, seg_a_start_x);
            day_reg   <= dif(seg_a_end_y, seg_a_start_y);
            dbx_reg   <= dif(seg_b_end_x, seg_b_start_x);
            dby_reg   <= dif(seg_b_end_y, seg_b_start_y);
            ox_reg    <= dif(seg_b_start_x, seg_a_start_x);
            oy_reg    <= dif(seg_b_start_y, seg_a_start_y);
            e1x_reg   <= dif(seg_b_end_x, seg_a_start_x);
            e1y_reg   <= dif(seg_b_end_y, seg_a_start_y);
            f1x_reg   <= dif(seg_a_end_x, seg_b_start_x);
            f1y_reg   <= dif(seg_a_end_y, seg_b_start_y);
            bx1_reg   <= seg_b_start_x;
            by1_reg   <= seg_b_start_y;
            both1_reg <= check_both;

            pd0_reg   <= dbx_reg * day_reg;
            pd1_reg   <= dby_reg * dax_reg;
            pr0_reg   <= oy_reg * dax_reg;
            pr1_reg   <= ox_reg * day_reg;
            ps0_reg   <= oy_reg * dbx_reg;
            ps1_reg   <= ox_reg * dby_reg;
            pa0_reg   <= dax_reg * e1y_reg;
            pa1_reg   <= day_reg * e1x_reg;
            pb0_reg   <= dby_reg * f1x_reg;
            pb1_reg   <= dbx_reg * f1y_reg;
            dbx2_reg  <= dbx_reg;
            dby2_reg  <= dby_reg;
            bx2_reg   <= bx1_reg;
            by2_reg   <= by1_reg;
            both2_reg <= both1_reg;

            d_reg     <= DET_W'(pd0_reg) - DET_W'(pd1_reg);
            rn_reg    <= DET_W'(pr0_reg) - DET_W'(pr1_reg);
            sn_reg    <= DET_W'(ps0_reg) - DET_W'(ps1_reg);
            oa_reg    <= DET_W'(pa0_reg) - DET_W'(pa1_reg);
            ob_reg    <= DET_W'(pb0_reg) - DET_W'(pb1_reg);
            dbx3_reg  <= dbx2_reg;
            dby3_reg  <= dby2_reg;
            bx3_reg   <= bx2_reg;
            by3_reg   <= by2_reg;
            both3_reg <= both2_reg;
        end
    end

    logic                    side_a, side_b, reject, in_range;
    logic signed [DET_W-1:0] dn, rnn, snn;

    always_comb
    begin
        side_a = (sgn_of(rn_reg) == sgn_of(oa_reg));
        side_b = (sgn_of(sn_reg) == sgn_of(ob_reg));
        reject = side_a && (!both3_reg || side_b);
        dn     = d_reg[DET_W-1]  ? -d_reg  : d_reg;
        rnn    = d_reg[DET_W-1]  ? -rn_reg : rn_reg;
        snn    = d_reg[DET_W-1]  ? -sn_reg : sn_reg;
        in_range = !rnn[DET_W-1] && !snn[DET_W-1] && (rnn <= dn) && (snn <= dn);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit4_reg  <= !reject && (d_reg != '0) && in_range;
            den4_reg  <= dn;
            rn4_reg   <= rnn;
            mx4_reg   <= dbx3_reg[DIFF_W-1] ? DIFF_W'(-dbx3_reg) : dbx3_reg;
            my4_reg   <= dby3_reg[DIFF_W-1] ? DIFF_W'(-dby3_reg) : dby3_reg;
            nx4_reg   <= dbx3_reg[DIFF_W-1];
            ny4_reg   <= dby3_reg[DIFF_W-1];
            bx4_reg   <= bx3_reg;
            by4_reg   <= by3_reg;

            nx5_reg   <= NUM_W'(rn4_reg) * NUM_W'(mx4_reg);
            ny5_reg   <= NUM_W'(rn4_reg) * NUM_W'(my4_reg);
            den5_reg  <= den4_reg;
            hit5_reg  <= hit4_reg;
            negx5_reg <= nx4_reg;
            negy5_reg <= ny4_reg;
            bx5_reg   <= bx4_reg;
            by5_reg   <= by4_reg;
        end
    end

    si_div_t div_data [QUO_W+1];
    logic    div_valid [QUO_W+1];

    always_comb
    begin
        div_valid[0]        = v5_reg;
        div_data[0].hit     = hit5_reg;
        div_data[0].neg_x   = negx5_reg;
        div_data[0].neg_y   = negy5_reg;
        div_data[0].start_x = bx5_reg;
        div_data[0].start_y = by5_reg;
        div_data[0].den     = den5_reg;
        div_data[0].rem_x   = nx5_reg[NUM_W-1:QUO_W];
        div_data[0].rem_y   = ny5_reg[NUM_W-1:QUO_W];
        div_data[0].low_x   = nx5_reg[QUO_W-1:0];
        div_data[0].low_y   = ny5_reg[QUO_W-1:0];
        div_data[0].quo_x   = '0;
        div_data[0].quo_y   = '0;
    end

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_cell
        si_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (div_valid[i]),
            .in_data   (div_data[i]),
            .out_valid (div_valid[i+1]),
            .out_data  (div_data[i+1])
        );
    end

    si_div_t              fin;
    logic signed [DIFF_W:0] sx, sy, qx, qy, rx, ry;

    always_comb
    begin
        fin = div_data[QUO_W];
        sx  = (DIFF_W+1)'(fin.start_x);
        sy  = (DIFF_W+1)'(fin.start_y);
        qx  = $signed({1'b0, fin.quo_x});
        qy  = $signed({1'b0, fin.quo_y});
        rx  = fin.neg_x ? sx - qx : sx + qx;
        ry  = fin.neg_y ? sy - qy : sy + qy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            vo_reg <= div_valid[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg <= fin.hit;
            cx_reg  <= fin.hit ? rx[W-1:0] : '0;
            cy_reg  <= fin.hit ? ry[W-1:0] : '0;
        end
    end

    assign out_valid = vo_reg;
    assign hit       = hit_reg;
    assign cross_x   = cx_reg;
    assign cross_y   = cy_reg;

endmodule

>>> rtl/core/si_checker.sv
module si_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_ready,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic                                  hit,
    input logic signed [si_pkg::COORD_WIDTH-1:0] cross_x,
    input logic signed [si_pkg::COORD_WIDTH-1:0] cross_y
);

    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow the output stage");

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (cross_x == '0 && cross_y == '0))
        else $error("result without a hit carries a nonzero point");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(hit) && $stable(cross_x) && $stable(cross_y)))
        else $error("result changed while stalled");

endmodule

bind segment_intersection si_checker u_si_checker (.*);
